>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clk; compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check held outside reset
`define LZWE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lzwe check failed");
// check held at every edge, reset included
`define LZWE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lzwe check failed");
`else
`define LZWE_ASSERT(lbl, prop)
`define LZWE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> src/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// shared widths, register indexes and the word issue record
// ----------------------------------------------------------------------------
package lzwe_pkg;

  localparam int BYTE_W            = 8;
  localparam int WORD_W            = 16;
  localparam int OUT_WORDS_W       = 14;
  localparam int COUNT_W           = 8;
  localparam int SRC_W             = 18;
  localparam int WCOUNT_W          = 3;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 14;
  localparam int DEF_HISTORY_WORDS = 8192;

  localparam logic [BYTE_W-1:0] NEAR_TAG_RST = 8'hA7;
  localparam logic [BYTE_W-1:0] FAR_TAG_RST  = 8'hA8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_WORDS = 2'd0,
    CFG_NEAR_TAG  = 2'd1,
    CFG_FAR_TAG   = 2'd2
  } cfg_reg_t;

  // one output word on its way from the sequencer to the packer
  typedef struct packed {
    logic [OUT_WORDS_W-1:0] pos;       // history position it lands on
    logic [WORD_W-1:0]      lit;       // value when not read from history
    logic                   from_mem;  // value comes from the history read
    logic                   bad;       // unwritten source, value is zero
    logic                   over;      // copy was clamped
    logic                   last;      // last word caused by this byte
    logic                   done;      // word total reaches the target
  } issue_t;

endpackage

>>> src/lzwe_ifs.sv
// ----------------------------------------------------------------------------
// lzwe channel interfaces
// byte input channel and packed word result channel, valid/ready
// ----------------------------------------------------------------------------
interface lzwe_byte_if;
  logic                          valid;
  logic                          ready;
  logic [lzwe_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzwe_word_if;
  logic                          valid;
  logic                          ready;
  logic [lzwe_pkg::WORD_W-1:0]   word_a;
  logic [lzwe_pkg::WORD_W-1:0]   word_b;
  logic [lzwe_pkg::WORD_W-1:0]   word_c;
  logic [lzwe_pkg::WORD_W-1:0]   word_d;
  logic [lzwe_pkg::WCOUNT_W-1:0] word_count;
  logic                          run_end;
  logic                          stream_done;
  logic                          bad_reference;
  logic                          overrun;

  modport source (output valid, output word_a, output word_b, output word_c,
                  output word_d, output word_count, output run_end,
                  output stream_done, output bad_reference, output overrun,
                  input ready);
  modport sink   (input valid, input word_a, input word_b, input word_c,
                  input word_d, input word_count, input run_end,
                  input stream_done, input bad_reference, input overrun,
                  output ready);
endinterface

>>> src/lzwe_hist_mem.sv
// ----------------------------------------------------------------------------
// lzwe_hist_mem
// history store: one write and one registered read port, with a bypass for
// a read of the entry written in the same cycle
// ----------------------------------------------------------------------------
module lzwe_hist_mem #(
  parameter int  HISTORY_WORDS = lzwe_pkg::DEF_HISTORY_WORDS,
  localparam int AW            = $clog2(HISTORY_WORDS)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lzwe_pkg::WORD_W-1:0] wr_data,
  output logic [lzwe_pkg::WORD_W-1:0] rd_data
);

  logic [lzwe_pkg::WORD_W-1:0] mem [HISTORY_WORDS];
  logic [lzwe_pkg::WORD_W-1:0] q;
  logic [lzwe_pkg::WORD_W-1:0] fwd_data;
  logic                        fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q        <= mem[rd_addr];
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // overlapping copy with offset one reads the word written alongside
  assign rd_data = fwd_hit ? fwd_data : q;

endmodule

>>> src/lzwe_parse.sv
// ----------------------------------------------------------------------------
// lzwe_parse
// token parser and copy sequencer: issues one word per cycle unless the packer
// stalls, literal or history read, with the source check against the live position
// ----------------------------------------------------------------------------
module lzwe_parse #(
  parameter int  HISTORY_WORDS = lzwe_pkg::DEF_HISTORY_WORDS,
  localparam int AW            = $clog2(HISTORY_WORDS)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rearm,
  input  logic [lzwe_pkg::OUT_WORDS_W-1:0] target,
  input  logic [lzwe_pkg::BYTE_W-1:0]      near_tag,
  input  logic [lzwe_pkg::BYTE_W-1:0]      far_tag,
  lzwe_byte_if.sink                        stream,
  output logic                             iss_valid,
  input  logic                             iss_ready,
  output lzwe_pkg::issue_t                 iss,
  output logic                             rd_en,
  output logic [AW-1:0]                    rd_addr
);

  localparam int OW = lzwe_pkg::OUT_WORDS_W;
  localparam int CW = lzwe_pkg::COUNT_W;
  localparam int SW = lzwe_pkg::SRC_W;
  localparam int BW = lzwe_pkg::BYTE_W;

  typedef enum logic [2:0] {
    PH_LOW      = 3'd0,
    PH_HIGH     = 3'd1,
    PH_ESC_NEAR = 3'd2,
    PH_ESC_FAR  = 3'd3,
    PH_NEAR_OFF = 3'd4,
    PH_FAR_LO   = 3'd5,
    PH_FAR_HI   = 3'd6
  } phase_t;

  phase_t                       phase;
  logic [CW-1:0]                left;
  logic [OW-1:0]                ipos;
  logic [BW-1:0]                held_low;
  logic [BW-1:0]                held_off;
  logic [SW-1:0]                src;
  logic                         is_lit;
  logic [lzwe_pkg::WORD_W-1:0]  lit_val;
  logic                         over;

  logic                         take;
  logic                         live;
  logic [OW-1:0]                rem;
  logic                         over_c;
  logic [CW-1:0]                n_c;
  logic [SW-1:0]                near_src;
  logic [SW-1:0]                far_src;
  logic                         src_ok;
  logic                         fire;

  assign stream.ready = (left == '0);
  assign take         = stream.valid && stream.ready;
  assign live         = ipos < target;
  assign rem          = target - ipos;
  assign over_c       = {{(OW-BW){1'b0}}, held_low} > rem;
  assign n_c          = over_c ? rem[CW-1:0] : held_low;
  assign near_src     = {{(SW-OW){1'b0}}, ipos} - {{(SW-BW){1'b0}}, stream.in_byte};
  assign far_src      = {{(SW-2*BW){1'b0}}, stream.in_byte, held_off};

  // source must be non-negative and below the position this word lands on
  assign src_ok = !src[SW-1] && (src[SW-2:0] < {{(SW-1-OW){1'b0}}, ipos});

  assign iss_valid    = (left != '0);
  assign fire         = iss_valid && iss_ready;
  assign iss.pos      = ipos;
  assign iss.lit      = is_lit ? lit_val : '0;
  assign iss.from_mem = !is_lit && src_ok;
  assign iss.bad      = !is_lit && !src_ok;
  assign iss.over     = over;
  assign iss.last     = (left == CW'(1));
  assign iss.done     = (ipos + OW'(1)) == target;
  assign rd_en        = fire && !is_lit && src_ok;
  assign rd_addr      = AW'(src);

  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      phase    <= PH_LOW;
      left     <= '0;
      ipos     <= '0;
      held_low <= '0;
      held_off <= '0;
    end else begin
      if (fire) begin
        left <= left - CW'(1);
        ipos <= ipos + OW'(1);
        src  <= src + SW'(1);
      end
      // bytes after the target is reached are taken and dropped
      if (take && live) begin
        case (phase)
          PH_HIGH: begin
            if (stream.in_byte == near_tag || stream.in_byte == far_tag) begin
              if (held_low == '0) begin
                phase <= (stream.in_byte == near_tag) ? PH_ESC_NEAR : PH_ESC_FAR;
              end else begin
                phase <= (stream.in_byte == near_tag) ? PH_NEAR_OFF : PH_FAR_LO;
              end
            end else begin
              left    <= CW'(1);
              is_lit  <= 1'b1;
              lit_val <= {stream.in_byte, held_low};
              over    <= 1'b0;
              phase   <= PH_LOW;
            end
          end
          PH_ESC_NEAR: begin
            left    <= CW'(1);
            is_lit  <= 1'b1;
            lit_val <= {near_tag, stream.in_byte};
            over    <= 1'b0;
            phase   <= PH_LOW;
          end
          PH_ESC_FAR: begin
            left    <= CW'(1);
            is_lit  <= 1'b1;
            lit_val <= {far_tag, stream.in_byte};
            over    <= 1'b0;
            phase   <= PH_LOW;
          end
          PH_NEAR_OFF: begin
            left   <= n_c;
            is_lit <= 1'b0;
            src    <= near_src;
            over   <= over_c;
            phase  <= PH_LOW;
          end
          PH_FAR_LO: begin
            held_off <= stream.in_byte;
            phase    <= PH_FAR_HI;
          end
          PH_FAR_HI: begin
            left   <= n_c;
            is_lit <= 1'b0;
            src    <= far_src;
            over   <= over_c;
            phase  <= PH_LOW;
          end
          default: begin
            held_low <= stream.in_byte;
            phase    <= PH_HIGH;
          end
        endcase
      end
    end
  end

endmodule

>>> src/lzwe_pack.sv
// ----------------------------------------------------------------------------
// lzwe_pack
// takes issued words into a stage register, writes them back to history and
// packs up to four into a result held in the output register
// ----------------------------------------------------------------------------
module lzwe_pack #(
  parameter int  HISTORY_WORDS = lzwe_pkg::DEF_HISTORY_WORDS,
  localparam int AW            = $clog2(HISTORY_WORDS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        iss_valid,
  output logic                        iss_ready,
  input  lzwe_pkg::issue_t            iss,
  input  logic [lzwe_pkg::WORD_W-1:0] mem_q,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [lzwe_pkg::WORD_W-1:0] wr_data,
  lzwe_word_if.source                 result
);

  localparam int WW = lzwe_pkg::WORD_W;

  logic             s1_valid;
  lzwe_pkg::issue_t s1;
  logic [WW-1:0]    grp_w [3];
  logic [1:0]       grp_cnt;
  logic             grp_bad;

  logic [WW-1:0]    word;
  logic             closes;
  logic             out_free;
  logic             consume;

  assign word     = s1.from_mem ? mem_q : s1.lit;
  assign closes   = (grp_cnt == 2'd3) || s1.last;
  assign out_free = !result.valid || result.ready;
  assign consume  = s1_valid && (!closes || out_free);
  assign iss_ready = !s1_valid || consume;

  assign wr_en   = consume;
  assign wr_addr = AW'(s1.pos);
  assign wr_data = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      grp_cnt      <= '0;
      grp_bad      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (iss_ready) begin
        s1_valid <= iss_valid;
      end
      if (consume) begin
        if (closes) begin
          grp_cnt <= '0;
          grp_bad <= 1'b0;
        end else begin
          grp_cnt <= grp_cnt + 2'd1;
          grp_bad <= grp_bad | s1.bad;
        end
      end
      if (consume && closes) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (iss_ready && iss_valid) begin
      s1 <= iss;
    end
    if (consume && !closes) begin
      grp_w[grp_cnt] <= word;
    end
    if (consume && closes) begin
      result.word_a        <= (grp_cnt == 2'd0) ? word : grp_w[0];
      result.word_b        <= (grp_cnt > 2'd1) ? grp_w[1] :
                              (grp_cnt == 2'd1) ? word : '0;
      result.word_c        <= (grp_cnt > 2'd2) ? grp_w[2] :
                              (grp_cnt == 2'd2) ? word : '0;
      result.word_d        <= (grp_cnt == 2'd3) ? word : '0;
      result.word_count    <= {1'b0, grp_cnt} + lzwe_pkg::WCOUNT_W'(1);
      result.run_end       <= s1.last;
      result.stream_done   <= s1.done;
      result.bad_reference <= grp_bad | s1.bad;
      result.overrun       <= s1.over;
    end
  end

endmodule

>>> src/lz_word_near_far_expand.sv
// ----------------------------------------------------------------------------
// lz_word_near_far_expand
// word-oriented lz expander with near (backward) and far (absolute) copies
// ----------------------------------------------------------------------------
// usage:
//   stream carries one compressed byte per beat; result carries up to four
//   produced words per beat with word_count, run_end on the last beat caused
//   by a byte, stream_done once the word target is reached, and error flags.
//   the config port writes out_words (rearms the parse and write position),
//   near_tag and far_tag; write only while the block is idle.
// timing:
//   a byte that yields n words occupies the sequencer while it issues them one
//   at a time, set by the single read port of the history store; each word
//   passes the sequencer registers and the packer's stage register, and a result
//   beat closes after four words or at the last word caused by the byte.
// reset:
//   rst clears the parser, position and output valid; tags go to a7/a8 and
//   out_words to zero, so bytes are dropped until out_words is written.
//   the history store is not cleared; unwritten entries are never read.
// stalls:
//   a held result beat lets the next four words gather, then the sequencer
//   and the byte input wait until the result beat is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lz_word_near_far_expand #(
  parameter int HISTORY_WORDS = lzwe_pkg::DEF_HISTORY_WORDS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lzwe_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lzwe_pkg::CFG_DATA_W-1:0] cfg_data,
  lzwe_byte_if.sink                       stream,
  lzwe_word_if.source                     result
);

  localparam int AW     = $clog2(HISTORY_WORDS);
  localparam int OW     = lzwe_pkg::OUT_WORDS_W;
  localparam int BW     = lzwe_pkg::BYTE_W;
  localparam int OW_MAX = (1 << OW) - 1;
  // target never exceeds what the store holds
  localparam int CAP_I  = (HISTORY_WORDS > OW_MAX) ? OW_MAX : HISTORY_WORDS;
  localparam logic [OW-1:0] HIST_CAP = OW'(CAP_I);

  // configuration registers
  logic [OW-1:0]     out_words;
  logic [BW-1:0]     near_tag;
  logic [BW-1:0]     far_tag;
  logic              rearm;
  logic [OW-1:0]     target;

  // sequencer to packer
  logic              iss_valid;
  logic              iss_ready;
  lzwe_pkg::issue_t  iss;

  // history ports
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [lzwe_pkg::WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [lzwe_pkg::WORD_W-1:0] wr_data;

  // writing out_words restarts the stream at position zero
  assign rearm  = cfg_we && (cfg_idx == lzwe_pkg::CFG_OUT_WORDS);
  assign target = (out_words > HIST_CAP) ? HIST_CAP : out_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_words <= '0;
      near_tag  <= lzwe_pkg::NEAR_TAG_RST;
      far_tag   <= lzwe_pkg::FAR_TAG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lzwe_pkg::CFG_OUT_WORDS: out_words <= cfg_data[OW-1:0];
        lzwe_pkg::CFG_NEAR_TAG:  near_tag  <= cfg_data[BW-1:0];
        lzwe_pkg::CFG_FAR_TAG:   far_tag   <= cfg_data[BW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // token parse and per-word issue, including the source range check
  lzwe_parse #(.HISTORY_WORDS(HISTORY_WORDS)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .rearm     (rearm),
    .target    (target),
    .near_tag  (near_tag),
    .far_tag   (far_tag),
    .stream    (stream),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss       (iss),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // history store, read issued by the parser, write-back by the packer
  lzwe_hist_mem #(.HISTORY_WORDS(HISTORY_WORDS)) u_hist (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // word write-back and result packing
  lzwe_pack #(.HISTORY_WORDS(HISTORY_WORDS)) u_pack (
    .clk       (clk),
    .rst       (rst),
    .iss_valid (iss_valid),
    .iss_ready (iss_ready),
    .iss       (iss),
    .mem_q     (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .result    (result)
  );

  // rearm leaves no word pending in the sequencer
  `LZWE_ASSERT(a_rearm_idle, rearm |=> !iss_valid)
  // no new byte is taken while a token's words are still being issued
  `LZWE_ASSERT(a_no_take_busy, (stream.valid && stream.ready) |-> !iss_valid)
  // the beat that completes the stream also closes its byte's run
  `LZWE_ASSERT(a_done_ends_run, (result.valid && result.stream_done) |-> result.run_end)
  // reset empties the output register
  `LZWE_ASSERT_ALWAYS(a_rst_out_empty, rst |=> !result.valid)

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for lz_word_near_far_expand: compressed bytes go in on
// the stream channel, every result beat is compared field by field against a
// word-history predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------
module testbench;

  localparam int HIST_WORDS  = lzwe_pkg::DEF_HISTORY_WORDS;
  localparam int WORD_W      = lzwe_pkg::WORD_W;
  localparam int WCOUNT_W    = lzwe_pkg::WCOUNT_W;
  localparam int CFG_IDX_W   = lzwe_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = lzwe_pkg::CFG_DATA_W;
  localparam int SETTLE      = 16;    // quiet cycles before a register write
  localparam int QUIET_LIMIT = 2000;  // cycles without any beat before giving up
  localparam int PRINT_CAP   = 50;

  // parser position inside a token
  typedef enum logic [2:0] {
    TOK_LO,
    TOK_HI,
    ESC_NEAR,
    ESC_FAR,
    NEAR_OFS,
    FAR_LO,
    FAR_HI
  } parse_t;

  // one result beat, word_a in words[0]
  typedef struct packed {
    logic [3:0][WORD_W-1:0] words;
    logic [WCOUNT_W-1:0]    count;
    logic                   run_end;
    logic                   done;
    logic                   bad;
    logic                   over;
  } word_beat_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts the words each stream byte produces and checks beats
  // --------------------------------------------------------------------------
  class expand_scoreboard;
    logic [WORD_W-1:0] hist [HIST_WORDS];
    int unsigned       wpos;
    parse_t            stage;
    logic [7:0]        held_count;
    logic [7:0]        held_pos_lo;
    int unsigned       out_words;
    logic [7:0]        near_tag;
    logic [7:0]        far_tag;
    word_beat_t        due[$];    // beats still owed by the block
    word_beat_t        batch[$];  // beats caused by the byte being noted
    word_beat_t        cur;
    int unsigned       cur_n;
    int                errors;
    int                beats;
    int                words;
    int                bad_beats;
    int                over_beats;
    int                consumed;

    function new();
      out_words   = 0;
      near_tag    = lzwe_pkg::NEAR_TAG_RST;
      far_tag     = lzwe_pkg::FAR_TAG_RST;
      wpos        = 0;
      stage       = TOK_LO;
      held_count  = '0;
      held_pos_lo = '0;
      errors      = 0;
      beats       = 0;
      words       = 0;
      bad_beats   = 0;
      over_beats  = 0;
      consumed    = 0;
    endfunction

    function int unsigned target();
      return (out_words > HIST_WORDS) ? HIST_WORDS : out_words;
    endfunction

    function bit finished();
      return wpos >= target();
    endfunction

    function void set_reg(lzwe_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        lzwe_pkg::CFG_OUT_WORDS: begin
          // rearm: position and parser start over, history stays
          out_words   = 32'(value);
          wpos        = 0;
          stage       = TOK_LO;
          held_count  = '0;
          held_pos_lo = '0;
        end
        lzwe_pkg::CFG_NEAR_TAG: near_tag = value[7:0];
        lzwe_pkg::CFG_FAR_TAG:  far_tag  = value[7:0];
        default: ;
      endcase
    endfunction

    function void close_beat();
      if (cur_n == 0) return;
      cur.count   = WCOUNT_W'(cur_n);
      cur.run_end = 1'b0;
      cur.done    = finished();
      batch.push_back(cur);
      cur   = '0;
      cur_n = 0;
    endfunction

    function void put_word(logic [WORD_W-1:0] w, bit bad, bit over);
      if (wpos < HIST_WORDS) hist[wpos] = w;
      wpos++;
      cur.words[cur_n] = w;
      cur_n++;
      cur.bad  = cur.bad | bad;
      cur.over = cur.over | over;
      if (cur_n == 4 || finished()) close_beat();
    endfunction

    // src may be negative; each word is checked against the live position
    function void copy_run(int src, int unsigned count);
      int unsigned room;
      bit          over;
      int unsigned n;
      int          s;
      room = target() - wpos;
      over = count > room;
      n    = over ? room : count;
      for (int unsigned i = 0; i < n; i++) begin
        s = src + int'(i);
        if (s >= 0 && s < int'(wpos)) put_word(hist[s], 1'b0, over);
        else put_word('0, 1'b1, over);
      end
    endfunction

    // returns 0 when the byte is dropped because the target was reached
    function bit note_byte(logic [7:0] b);
      batch.delete();
      cur   = '0;
      cur_n = 0;
      if (finished()) return 1'b0;
      consumed++;
      case (stage)
        TOK_HI: begin
          if (b == near_tag) begin
            if (held_count == 0) stage = ESC_NEAR;
            else stage = NEAR_OFS;
          end else if (b == far_tag) begin
            if (held_count == 0) stage = ESC_FAR;
            else stage = FAR_LO;
          end else begin
            put_word({b, held_count}, 1'b0, 1'b0);
            stage = TOK_LO;
          end
        end
        ESC_NEAR: begin
          put_word({near_tag, b}, 1'b0, 1'b0);
          stage = TOK_LO;
        end
        ESC_FAR: begin
          put_word({far_tag, b}, 1'b0, 1'b0);
          stage = TOK_LO;
        end
        NEAR_OFS: begin
          copy_run(int'(wpos) - int'(b), 32'(held_count));
          stage = TOK_LO;
        end
        FAR_LO: begin
          held_pos_lo = b;
          stage = FAR_HI;
        end
        FAR_HI: begin
          copy_run(int'({b, held_pos_lo}), 32'(held_count));
          stage = TOK_LO;
        end
        default: begin
          held_count = b;
          stage = TOK_HI;
        end
      endcase
      close_beat();
      if (batch.size() > 0) batch[batch.size() - 1].run_end = 1'b1;
      foreach (batch[i]) due.push_back(batch[i]);
      return 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_beat(word_beat_t got);
      word_beat_t want;
      if (due.size() == 0) begin
        report($sformatf("beat with nothing expected, word_a %h count %0d",
                         got.words[0], got.count));
        return;
      end
      want = due.pop_front();
      beats++;
      for (int i = 0; i < 4; i++)
        if (got.words[i] !== want.words[i])
          report($sformatf("beat %0d word %0d got %h want %h",
                           beats, i, got.words[i], want.words[i]));
      if (got.count !== want.count)
        report($sformatf("beat %0d word_count got %0d want %0d", beats, got.count,
                         want.count));
      if (got.run_end !== want.run_end)
        report($sformatf("beat %0d run_end got %b want %b", beats, got.run_end,
                         want.run_end));
      if (got.done !== want.done)
        report($sformatf("beat %0d stream_done got %b want %b", beats, got.done,
                         want.done));
      if (got.bad !== want.bad)
        report($sformatf("beat %0d bad_reference got %b want %b", beats, got.bad,
                         want.bad));
      if (got.over !== want.over)
        report($sformatf("beat %0d overrun got %b want %b", beats, got.over,
                         want.over));
      words += int'(want.count);
      if (want.bad) bad_beats++;
      if (want.over) over_beats++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lzwe_byte_if stream ();
  lzwe_word_if result ();

  expand_scoreboard sb;
  bit steady;     // no idling on either side while set
  int hold_left;  // remaining cycles of the current result stall
  int quiet;      // cycles since the last beat or register write
  int sent;       // every byte accepted, dropped ones included
  int settings;   // register settings applied

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  lz_word_near_far_expand dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .stream   (stream),
    .result   (result)
  );

  // idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // copy count: mostly a few words, sometimes up to the full 255; long runs take 200 to 255
  function automatic int unsigned copy_len(bit long_runs);
    if (long_runs) return $urandom_range(200, 255);
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 8);
    return $urandom_range(9, 255);
  endfunction

  // result side: check each taken beat, then pick ready for the next cycle;
  // signals are read at the edge, before this edge's updates land
  always @(posedge clk) begin : take_results
    word_beat_t got;
    if (result.valid && result.ready) begin
      got = {result.word_d, result.word_c, result.word_b, result.word_a,
             result.word_count, result.run_end, result.stream_done,
             result.bad_reference, result.overrun};
      sb.check_beat(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      hold_left = idle_len() - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  // watchdog: a stuck block shows up as a long stretch with no beat at all
  always @(posedge clk) begin
    if ((stream.valid && stream.ready) || (result.valid && result.ready) || cfg_we)
      quiet = 0;
    else
      quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d beats outstanding",
               QUIET_LIMIT, sb.due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus tasks; each one starts and ends right after a rising edge
  // --------------------------------------------------------------------------

  // one byte beat, noted in the predictor at the edge that takes it;
  // valid stays high into the next call unless a gap follows
  task automatic send_byte(logic [7:0] b);
    stream.valid   <= 1'b1;
    stream.in_byte <= b;
    do @(posedge clk); while (!stream.ready);
    void'(sb.note_byte(b));
    sent++;
    if (!steady && $urandom_range(0, 99) < 40) begin
      stream.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // hold the stream until every owed beat has come back
  task automatic wait_drained();
    stream.valid <= 1'b0;
    do @(posedge clk); while (sb.due.size() != 0);
  endtask

  // register write; the caller lowers cfg_we after the last one
  task automatic write_reg(lzwe_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // new tags and word target, only once the block has gone quiet; a byte
  // that only moves the parser has no beat to wait for, hence the settle time
  task automatic apply_settings(int unsigned words_wanted, logic [7:0] near,
                                logic [7:0] far, bit calm);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    steady = calm;
    write_reg(lzwe_pkg::CFG_NEAR_TAG, CFG_DATA_W'(near));
    write_reg(lzwe_pkg::CFG_FAR_TAG, CFG_DATA_W'(far));
    write_reg(lzwe_pkg::CFG_OUT_WORDS, CFG_DATA_W'(words_wanted));
    cfg_we <= 1'b0;
    settings++;
  endtask

  // one well-formed token with random content, or a little noise
  task automatic send_token(bit long_runs);
    logic [7:0]  q[$];
    int unsigned pick;
    int unsigned wp;
    logic [7:0]  hi;
    logic [7:0]  ofs;
    logic [15:0] pos;
    wp   = sb.wpos;
    pick = long_runs ? $urandom_range(50, 87) : $urandom_range(0, 99);
    // equal tags leave no far copy; fall back to a near one
    if (pick >= 70 && pick < 88 && sb.near_tag == sb.far_tag) pick = 60;
    if (pick < 30) begin
      // plain literal, high byte clear of both tags
      do hi = 8'($urandom); while (hi == sb.near_tag || hi == sb.far_tag);
      q = '{8'($urandom), hi};
    end else if (pick < 40) begin
      q = '{8'h00, sb.near_tag, 8'($urandom)};
    end else if (pick < 48) begin
      q = '{8'h00, sb.far_tag, 8'($urandom)};
    end else if (pick < 70) begin
      // near copy, mostly from written history
      if (wp > 0 && $urandom_range(0, 9) < 8)
        ofs = 8'($urandom_range(1, wp < 255 ? wp : 255));
      else ofs = 8'($urandom);
      q = '{8'(copy_len(long_runs)), sb.near_tag, ofs};
    end else if (pick < 88) begin
      // far copy, mostly from written history
      if (wp > 0 && $urandom_range(0, 9) < 8) pos = 16'($urandom_range(0, wp - 1));
      else pos = 16'($urandom);
      q = '{8'(copy_len(long_runs)), sb.far_tag, pos[7:0], pos[15:8]};
    end else begin
      // noise that may leave the parser in the middle of a token
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
    end
    foreach (q[i]) send_byte(q[i]);
  endtask

  // one setting: tokens until the target is met or the byte budget is spent,
  // then a few bytes more, which the block drops once it is done
  task automatic run_phase(int unsigned words_wanted, logic [7:0] near,
                           logic [7:0] far, int unsigned budget, bit calm,
                           bit long_runs, bit pause_mid);
    int unsigned start;
    bit          paused;
    apply_settings(words_wanted, near, far, calm);
    start  = sb.consumed;
    paused = 1'b0;
    while (!sb.finished() && sb.consumed - start < budget) begin
      send_token(long_runs);
      if (pause_mid && !paused && sb.consumed - start >= 8) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
  endtask

  // hand-picked tokens with the reset tags: extremes, both escapes,
  // overlapping copy, zero offset, unwritten far source and a clamped copy
  task automatic run_directed();
    logic [7:0] q[$];
    apply_settings(21, lzwe_pkg::NEAR_TAG_RST, lzwe_pkg::FAR_TAG_RST, 1'b0);
    q = '{8'h00, 8'h00,                                // literal 0000
          8'hFF, 8'hFF,                                // literal ffff
          8'h00, lzwe_pkg::NEAR_TAG_RST, 8'h5A,        // near escape
          8'h00, lzwe_pkg::FAR_TAG_RST, 8'hFF,         // far escape
          8'h03, lzwe_pkg::NEAR_TAG_RST, 8'h01,        // offset one repeats
          8'h02, lzwe_pkg::NEAR_TAG_RST, 8'h00,        // offset zero, zeros
          8'h04, lzwe_pkg::FAR_TAG_RST, 8'h00, 8'h00,  // copy from the start
          8'h02, lzwe_pkg::FAR_TAG_RST, 8'h00, 8'hFF,  // past the write point
          8'hFF, lzwe_pkg::NEAR_TAG_RST, 8'h05};       // cut at the target
    foreach (q[i]) send_byte(q[i]);
  endtask

  // --------------------------------------------------------------------------
  // run
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] near;
    logic [7:0] far;
    sb = new();
    steady    = 1'b0;
    hold_left = 0;
    quiet     = 0;
    sent      = 0;
    settings  = 0;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_idx        <= lzwe_pkg::CFG_OUT_WORDS;
    cfg_data       <= '0;
    stream.valid   <= 1'b0;
    stream.in_byte <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // word target is zero out of reset, so this byte is dropped
    send_byte(8'h3C);
    run_directed();

    // tag extremes, with one full drain partway through
    run_phase(60, 8'h00, 8'hFF, 200, 1'b0, 1'b0, 1'b1);
    run_phase(1, 8'hFF, 8'h00, 20, 1'b1, 1'b0, 1'b0);
    // zero target: everything is dropped
    run_phase(0, 8'($urandom), 8'($urandom), 10, 1'b0, 1'b0, 1'b0);
    // huge target, rearmed long before it is reached
    run_phase(8191, 8'($urandom), 8'($urandom), 30, 1'b0, 1'b0, 1'b0);
    // whole history filled with long copies
    run_phase(HIST_WORDS, lzwe_pkg::NEAR_TAG_RST, lzwe_pkg::FAR_TAG_RST, 400,
              1'b0, 1'b1, 1'b0);
    // equal tags: near meaning wins
    run_phase(90, 8'h5A, 8'h5A, 120, 1'b0, 1'b0, 1'b0);

    while (sb.consumed < 290) begin
      near = 8'($urandom);
      far  = ($urandom_range(0, 7) == 0) ? near : 8'($urandom);
      run_phase($urandom_range(1, 300), near, far, $urandom_range(20, 80),
                $urandom_range(0, 3) == 0, 1'b0, 1'b0);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d stream bytes (%0d parsed) across %0d register settings",
             sent, sb.consumed, settings);
    $display("checked %0d result beats, %0d words, %0d with bad references, %0d clamped",
             sb.beats, sb.words, sb.bad_beats, sb.over_beats);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
